@@ design/p2re_pkg.sv @@
// Shared types, constants and codes for the packed 2-bit-per-pixel raster op engine.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package p2re_pkg;

   // Frame store geometry.
   localparam int STORE_BYTES = 65536;
   localparam int ADDR_W      = $clog2(STORE_BYTES);

   // Field and datapath widths.
   localparam int COORD_W  = 12;
   localparam int LEN_W    = 13;
   localparam int STRIDE_W = 11;
   localparam int CNT_W    = 13;
   localparam int PROD_W   = 24;
   localparam int LAST_W   = 25;

   // Register port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_ROW_STRIDE = 1'b0;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd160;

   typedef enum logic [1:0] {
      OPC_READ  = 2'd0,
      OPC_DRAW  = 2'd1,
      OPC_HSPAN = 2'd2,
      OPC_VSPAN = 2'd3
   } p2re_opcode_type;

   typedef enum logic [1:0] {
      ROP_WRITE = 2'd0,
      ROP_XOR   = 2'd1,
      ROP_OR    = 2'd2,
      ROP_AND   = 2'd3
   } p2re_rop_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_BASE,
      ST_MUL_SPAN,
      ST_CHECK,
      ST_DISPATCH,
      ST_READ,
      ST_WRITE,
      ST_DONE
   } p2re_state_type;

   // One input item as held inside the block.
   typedef struct packed {
      p2re_opcode_type    opcode;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [LEN_W-1:0]   span_length;
      logic [1:0]         pixel_color;
      p2re_rop_type       raster_op;
   } p2re_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic mul_base;
      logic mul_span;
      logic check;
      logic mem_read;
      logic mem_write;
      logic load_out;
   } p2re_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      p2re_opcode_type opcode;
      logic            bypass;
      logic            last_byte;
   } p2re_status_type;

endpackage

`default_nettype wire

@@ design/p2re_if.sv @@
// Valid/ready channel interfaces for the item and result channels.
// Depends on p2re_pkg for field widths.
`default_nettype none

interface p2re_req_if import p2re_pkg::*;;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [COORD_W-1:0] pos_x;
   logic [COORD_W-1:0] pos_y;
   logic [LEN_W-1:0]   span_length;
   logic [1:0]         pixel_color;
   logic [1:0]         raster_op;

   modport source (
      output valid, opcode, pos_x, pos_y, span_length, pixel_color, raster_op,
      input  ready
   );
   modport sink (
      input  valid, opcode, pos_x, pos_y, span_length, pixel_color, raster_op,
      output ready
   );
endinterface

interface p2re_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] read_value;
   logic       address_error;

   modport source (output valid, read_value, address_error, input ready);
   modport sink (input valid, read_value, address_error, output ready);
endinterface

`default_nettype wire

@@ design/packed_2bpp_raster_op_engine.sv @@
// Channel     | Direction | Handshake          | Payload
// req         | in        | valid/ready        | opcode, pos_x, pos_y, span_length, color, rop
// rsp         | out       | valid/ready        | read_value, address_error
// csr (APB)   | in        | psel/penable/pready| row_stride_bytes at byte address 0
//
// Accept in an idle cycle, then address multiply (base, then span), range check and dispatch;
// for each frame store byte a read, then a write through the one memory port; then a result
// load. A read skips the write, and an out-of-range or skipped item goes from dispatch to the
// result load. The next item is taken only back in idle, after the last result is loaded.
// Reset is synchronous and active high; the frame store is not cleared.
// A waiting result does not block the next item, which stalls in its result-load cycle.
//
// Top level: register port, channel adaptation, controller and datapath.
// Depends on p2re_pkg, p2re_if, p2re_ctrl and p2re_datapath.
`default_nettype none

module packed_2bpp_raster_op_engine import p2re_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   p2re_req_if.sink              req,
   p2re_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [STRIDE_W-1:0] row_stride_ff, row_stride_in;
   logic                csr_write;
   p2re_item_type       item;
   p2re_cmd_type        cmd;
   p2re_status_type     status;

   // Row stride register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_IDX_ROW_STRIDE);
   assign row_stride_in = csr_write ? pwdata[STRIDE_W-1:0] : row_stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_stride_ff <= STRIDE_RESET;
      end else begin
         row_stride_ff <= row_stride_in;
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_ROW_STRIDE) ? CSR_DATA_W'(row_stride_ff) : '0;

   // Pack the incoming item.
   assign item.opcode      = p2re_opcode_type'(req.opcode);
   assign item.pos_x       = req.pos_x;
   assign item.pos_y       = req.pos_y;
   assign item.span_length = req.span_length;
   assign item.pixel_color = req.pixel_color;
   assign item.raster_op   = p2re_rop_type'(req.raster_op);

   p2re_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   p2re_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .item          (item),
      .row_stride    (row_stride_ff),
      .read_value    (rsp.read_value),
      .address_error (rsp.address_error)
   );

endmodule

`default_nettype wire

@@ design/p2re_ctrl.sv @@
// Controller state machine: sequences multiply, range check and per-byte read-modify-write.
// Depends on p2re_pkg for the state, command and status types.
`default_nettype none

module p2re_ctrl import p2re_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output p2re_cmd_type    cmd,
   input  p2re_status_type status
);

   p2re_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Command outputs.
   always_comb begin
      cmd           = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_MUL_BASE: cmd.mul_base  = 1'b1;
         ST_MUL_SPAN: cmd.mul_span  = 1'b1;
         ST_CHECK:    cmd.check     = 1'b1;
         ST_DISPATCH: ;
         ST_READ:     cmd.mem_read  = 1'b1;
         ST_WRITE:    cmd.mem_write = 1'b1;
         ST_DONE:     cmd.load_out  = !out_valid_ff || rsp_ready;
      endcase
   end

   // The result register frees as soon as the item is taken.
   always_comb begin
      priority if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL_BASE;
            end
         end
         ST_MUL_BASE: state_in = ST_MUL_SPAN;
         ST_MUL_SPAN: state_in = ST_CHECK;
         ST_CHECK:    state_in = ST_DISPATCH;
         ST_DISPATCH: state_in = status.bypass ? ST_DONE : ST_READ;
         ST_READ:     state_in = (status.opcode == OPC_READ) ? ST_DONE : ST_WRITE;
         ST_WRITE:    state_in = status.last_byte ? ST_DONE : ST_READ;
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

`ifndef SYNTHESIS
   // A byte is never written for an item that was found out of range or skipped.
   a_no_write_on_bypass: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> !status.bypass)
      else $error("write issued for a bypassed item");

   // A loaded result is presented on the next cycle.
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> out_valid_ff)
      else $error("result loaded but not presented");

   // An offered item is taken from idle and starts the address multiply.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && req_valid |=> state_ff == ST_MUL_BASE)
      else $error("accepted item did not start");
`endif

endmodule

`default_nettype wire

@@ design/p2re_datapath.sv @@
// Datapath: address multiply, range check, edge masks, frame store and result register.
// Depends on p2re_pkg for widths, codes and the command and status structs.
`default_nettype none

module p2re_datapath import p2re_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  p2re_cmd_type        cmd,
   output p2re_status_type     status,
   input  p2re_item_type       item,
   input  logic [STRIDE_W-1:0] row_stride,
   output logic [1:0]          read_value,
   output logic                address_error
);

   // Combine the color pattern into a byte under a mask.
   function automatic logic [7:0] raster_combine(input logic [7:0] d, input logic [7:0] m,
                                                 input logic [7:0] cv, input p2re_rop_type rop);
      logic [7:0] r;
      unique case (rop)
         ROP_WRITE: r = (d & ~m) | (cv & m);
         ROP_XOR:   r = d ^ (cv & m);
         ROP_OR:    r = d | (cv & m);
         ROP_AND:   r = d & (cv | ~m);
      endcase
      return r;
   endfunction

   logic [7:0]        frame_store_ff [STORE_BYTES];
   p2re_item_type     item_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] base_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              first_ff;
   logic              err_ff, err_in;
   logic              bypass_ff, bypass_in;
   logic [7:0]        rdata_ff;
   logic [1:0]        read_value_ff;
   logic              address_error_ff;

   logic [LEN_W-1:0]   mul_a;
   logic [PROD_W-1:0]  mul_out;
   logic [13:0]        end_pos;
   logic [13:0]        end_m1;
   logic [11:0]        hoff;
   logic [LAST_W-1:0]  offset;
   logic [LAST_W-1:0]  last_addr;
   logic               is_span, len_zero, noop;
   logic [CNT_W-1:0]   cnt_in;
   logic [1:0]         end_lo_neg;
   logic [7:0]         lm, rm, pix_mask, byte_mask, cv;
   logic [7:0]         rd_shifted;
   logic [ADDR_W-1:0]  step;

   // Shared multiplier: row times stride, then (length - 1) times stride.
   assign mul_a   = cmd.mul_base ? {1'b0, item_ff.pos_y} : item_ff.span_length - LEN_W'(1);
   assign mul_out = mul_a * row_stride;

   // Horizontal span extent in bytes, less one.
   assign end_pos = {2'b00, item_ff.pos_x} + {1'b0, item_ff.span_length};
   assign end_m1  = end_pos - 14'd1;
   assign hoff    = end_m1[13:2] - {2'b00, item_ff.pos_x[11:2]};

   // Last byte touched and the range check against the store size.
   always_comb begin
      unique case (item_ff.opcode)
         OPC_HSPAN: offset = LAST_W'(hoff);
         OPC_VSPAN: offset = LAST_W'(prod_ff);
         default:   offset = '0;
      endcase
   end
   assign last_addr = LAST_W'(base_ff) + offset;

   assign is_span  = (item_ff.opcode == OPC_HSPAN) || (item_ff.opcode == OPC_VSPAN);
   assign len_zero = (item_ff.span_length == '0);
   assign noop     = ((item_ff.raster_op == ROP_XOR || item_ff.raster_op == ROP_OR)
                      && item_ff.pixel_color == 2'd0)
                  || (item_ff.raster_op == ROP_AND && item_ff.pixel_color == 2'd3);
   assign err_in    = !(is_span && len_zero) && (last_addr >= LAST_W'(STORE_BYTES));
   assign bypass_in = err_in || (is_span && (len_zero || noop));

   // Bytes to visit.
   always_comb begin
      unique case (item_ff.opcode)
         OPC_HSPAN: cnt_in = {1'b0, hoff} + CNT_W'(1);
         OPC_VSPAN: cnt_in = item_ff.span_length;
         default:   cnt_in = CNT_W'(1);
      endcase
   end

   // Edge masks and color pattern.
   assign end_lo_neg = 2'b00 - end_pos[1:0];
   assign lm         = 8'hff << {item_ff.pos_x[1:0], 1'b0};
   assign rm         = 8'hff >> {end_lo_neg, 1'b0};
   assign pix_mask   = 8'h03 << {item_ff.pos_x[1:0], 1'b0};
   assign cv         = {4{item_ff.pixel_color}};

   always_comb begin
      if (item_ff.opcode == OPC_HSPAN) begin
         byte_mask = (first_ff ? lm : 8'hff) & ((cnt_ff == CNT_W'(1)) ? rm : 8'hff);
      end else begin
         byte_mask = pix_mask;
      end
   end

   assign step       = (item_ff.opcode == OPC_VSPAN) ? ADDR_W'(row_stride) : ADDR_W'(1);
   assign rd_shifted = rdata_ff >> {item_ff.pos_x[1:0], 1'b0};

   // Item, multiply and walk registers.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= item;
      end
      if (cmd.mul_base || cmd.mul_span) begin
         prod_ff <= mul_out;
      end
      if (cmd.mul_span) begin
         base_ff <= prod_ff + PROD_W'(item_ff.pos_x[11:2]);
      end
      if (cmd.check) begin
         addr_ff  <= base_ff[ADDR_W-1:0];
         cnt_ff   <= cnt_in;
         first_ff <= 1'b1;
      end else if (cmd.mem_write) begin
         addr_ff  <= addr_ff + step;
         cnt_ff   <= cnt_ff - CNT_W'(1);
         first_ff <= 1'b0;
      end
   end

   // Check flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff    <= 1'b0;
         bypass_ff <= 1'b0;
      end else if (cmd.check) begin
         err_ff    <= err_in;
         bypass_ff <= bypass_in;
      end
   end

   // Frame store with registered read.
   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rdata_ff <= frame_store_ff[addr_ff];
      end
      if (cmd.mem_write) begin
         frame_store_ff[addr_ff] <= raster_combine(rdata_ff, byte_mask, cv, item_ff.raster_op);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         read_value_ff    <= (item_ff.opcode == OPC_READ && !err_ff) ? rd_shifted[1:0] : 2'd0;
         address_error_ff <= err_ff;
      end
   end

   assign read_value       = read_value_ff;
   assign address_error    = address_error_ff;
   assign status.opcode    = item_ff.opcode;
   assign status.bypass    = bypass_ff;
   assign status.last_byte = (cnt_ff == CNT_W'(1));

`ifndef SYNTHESIS
   // The byte counter never runs out while bytes are still being written.
   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |-> cnt_ff != '0)
      else $error("byte write with empty counter");

   // An address error always suppresses the memory walk.
   a_err_bypass: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> bypass_ff)
      else $error("address error without bypass");

   // Single-pixel items visit exactly one byte.
   a_pixel_one_byte: assert property (@(posedge clock) disable iff (reset)
      cmd.check && (item_ff.opcode == OPC_READ || item_ff.opcode == OPC_DRAW)
      |=> cnt_ff == CNT_W'(1))
      else $error("pixel item with byte count other than one");
`endif

endmodule

`default_nettype wire
